// File: src/cpd_pkg.sv
`default_nettype none

package cpd_pkg;

    // framing bytes
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;

    // count byte decode
    localparam int unsigned WIDE_BIT = 4;
    localparam logic [3:0] COUNT_ONE = 4'd1;
    localparam logic [3:0] COUNT_TWO = 4'd2;

    // header storage and length range
    localparam int unsigned HEADER_DEPTH = 6;
    localparam int unsigned LENGTH_W = 6;
    localparam logic [LENGTH_W-1:0] LENGTH_MAX = 6'd63;

    typedef logic [7:0] t_byte;
    typedef t_byte t_header [HEADER_DEPTH];

    // input request
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in;

    // decoded packet header
    typedef struct packed {
        logic [7:0]          target_num;
        logic [7:0]          target_kind;
        logic [7:0]          function_code;
        logic [7:0]          count_byte;
        logic [15:0]         param_one;
        logic [7:0]          param_two;
        logic [LENGTH_W-1:0] packet_length;
        logic                overflow;
    } t_result;

    // result handoff from the framer to the output buffer
    typedef struct packed {
        logic    valid;
        t_result data;
    } t_push;

endpackage

`default_nettype wire

// File: src/cpd_if.sv
`default_nettype none

// byte request channel
interface cpd_rx_if;
    logic         valid;
    logic         ready;
    cpd_pkg::t_in payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// packet header request channel
interface cpd_pkt_if;
    logic             valid;
    logic             ready;
    cpd_pkg::t_result payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/cpd_framer.sv
`default_nettype none

module cpd_framer #(
    parameter int unsigned MAX_PACKET = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  wire logic [7:0]  i_rx_byte,
    output cpd_pkg::t_push   o_push
);

    localparam int unsigned CW = $clog2(MAX_PACKET + 1);
    localparam int unsigned LW = (CW > cpd_pkg::LENGTH_W) ? CW : cpd_pkg::LENGTH_W;
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_PACKET);

    cpd_pkg::t_header r_hdr;
    cpd_pkg::t_header n_hdr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_nl;
    logic             r_ovf;
    logic             n_ovf;
    logic [15:0]      r_param_one;
    logic [15:0]      n_param_one;
    logic [7:0]       r_param_two;
    logic [7:0]       n_param_two;

    logic             is_lf;
    logic             is_cr;
    logic             do_store;
    logic             has_room;
    logic             do_close;
    logic [LW-1:0]    len_ext;
    logic [cpd_pkg::LENGTH_W-1:0] len_sat;

    // byte classification
    assign is_lf    = (i_rx_byte == cpd_pkg::BYTE_LF);
    assign is_cr    = (i_rx_byte == cpd_pkg::BYTE_CR);
    assign do_store = is_lf || !r_nl || is_cr;
    assign do_close = !is_lf && r_nl && is_cr;
    assign has_room = (r_count < COUNT_LIMIT);

    // header, count and overflow after storing this byte
    always_comb begin
        n_hdr = r_hdr;
        for (int i = 0; i < cpd_pkg::HEADER_DEPTH; i++) begin
            if (do_store && has_room && (r_count == CW'(i))) begin
                n_hdr[i] = i_rx_byte;
            end
        end
        n_count = r_count + CW'(do_store && has_room);
        n_ovf   = r_ovf || (do_store && !has_room);
    end

    // parameter decode from the count byte
    always_comb begin
        n_param_one = r_param_one;
        n_param_two = r_param_two;
        priority if (n_hdr[3][cpd_pkg::WIDE_BIT]) begin
            n_param_one = {n_hdr[5], n_hdr[4]};
        end else if (n_hdr[3][3:0] == cpd_pkg::COUNT_ONE) begin
            n_param_one = {8'h00, n_hdr[4]};
        end else if (n_hdr[3][3:0] == cpd_pkg::COUNT_TWO) begin
            n_param_one = {8'h00, n_hdr[4]};
            n_param_two = n_hdr[5];
        end else begin
            // other counts keep both held parameters
            n_param_one = r_param_one;
            n_param_two = r_param_two;
        end
    end

    // saturated length
    assign len_ext = LW'(n_count);
    assign len_sat = (len_ext > LW'(cpd_pkg::LENGTH_MAX)) ? cpd_pkg::LENGTH_MAX
                                                          : len_ext[cpd_pkg::LENGTH_W-1:0];

    // result for a closed packet
    always_comb begin
        o_push.valid              = i_accept && do_close;
        o_push.data.target_num    = n_hdr[0];
        o_push.data.target_kind   = n_hdr[1];
        o_push.data.function_code = n_hdr[2];
        o_push.data.count_byte    = n_hdr[3];
        o_push.data.param_one     = n_param_one;
        o_push.data.param_two     = n_param_two;
        o_push.data.packet_length = len_sat;
        o_push.data.overflow      = n_ovf;
    end

    // packet state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cpd_pkg::HEADER_DEPTH; i++) begin
                r_hdr[i] <= '0;
            end
            r_count     <= '0;
            r_nl        <= 1'b0;
            r_ovf       <= 1'b0;
            r_param_one <= '0;
            r_param_two <= '0;
        end else if (i_accept) begin
            if (do_close) begin
                for (int i = 0; i < cpd_pkg::HEADER_DEPTH; i++) begin
                    r_hdr[i] <= '0;
                end
                r_count     <= '0;
                r_nl        <= 1'b0;
                r_ovf       <= 1'b0;
                r_param_one <= n_param_one;
                r_param_two <= n_param_two;
            end else if (do_store) begin
                r_hdr   <= n_hdr;
                r_count <= n_count;
                r_ovf   <= n_ovf;
                if (is_lf) begin
                    r_nl <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: src/cpd_out_buf.sv
`default_nettype none

module cpd_out_buf (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire cpd_pkg::t_push i_push,
    output logic             o_space,
    output logic             o_valid,
    input  wire              i_ready,
    output cpd_pkg::t_result o_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    cpd_pkg::t_result r_main;
    cpd_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_main_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // two-entry queue: head register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (pop && r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= i_push.valid;
                if (i_push.valid) begin
                    r_skid <= i_push.data;
                end
            end else if (pop) begin
                r_main_valid <= i_push.valid;
                if (i_push.valid) begin
                    r_main <= i_push.data;
                end
            end else if (i_push.valid) begin
                if (!r_main_valid) begin
                    r_main       <= i_push.data;
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid       <= i_push.data;
                    r_skid_valid <= 1'b1;
                end
            end else begin
                // nothing moves, queue holds
            end
        end
    end

endmodule

`default_nettype wire

// File: src/command_packet_deframer_unit.sv
`default_nettype none
// a closing carriage return registers its header into the output queue on acceptance
// throughput: one byte per cycle unless the queue is full, from the single-pass framer update
// a two-entry output queue keeps bytes flowing while one header waits
// reset (synchronous, active low) clears the header bytes, count, flags,
// held parameters and the output queue

module command_packet_deframer_unit #(
    parameter int unsigned MAX_PACKET = 32
) (
    input wire         i_clk,
    input wire         i_rst_n,
    cpd_rx_if.sink     i_rx,
    cpd_pkt_if.source  o_pkt
);

    logic           accept;
    logic           space;
    cpd_pkg::t_push push;

    // input handshake
    assign i_rx.ready = space;
    assign accept     = i_rx.valid && space;

    // per-byte framing and header decode
    cpd_framer #(
        .MAX_PACKET (MAX_PACKET)
    ) u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx.payload.rx_byte),
        .o_push    (push)
    );

    // result queue
    cpd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_pkt.valid),
        .i_ready (o_pkt.ready),
        .o_data  (o_pkt.payload)
    );

endmodule

`default_nettype wire
